// ===== design/cihe_pkg.sv =====
// Shared types and constants for the CBOR item head encoder.
package cihe_pkg;

    // Input item kinds
    typedef enum logic [3:0] {
        KIND_RESTART  = 4'd0,
        KIND_UNSIGNED = 4'd1,
        KIND_SIGNED   = 4'd2,
        KIND_BOOL     = 4'd3,
        KIND_BYTES    = 4'd4,
        KIND_TEXT     = 4'd5,
        KIND_ARRAY    = 4'd6,
        KIND_MAP      = 4'd7,
        KIND_PAYLOAD  = 4'd8
    } kind_t;

    // CBOR major types
    localparam logic [2:0] MT_UNSIGNED = 3'd0;
    localparam logic [2:0] MT_NEGATIVE = 3'd1;
    localparam logic [2:0] MT_BYTES    = 3'd2;
    localparam logic [2:0] MT_TEXT     = 3'd3;
    localparam logic [2:0] MT_ARRAY    = 3'd4;
    localparam logic [2:0] MT_MAP      = 3'd5;

    // Additional-information codes for the argument size
    localparam logic [4:0] AI_ONE_BYTE  = 5'd24;
    localparam logic [4:0] AI_TWO_BYTE  = 5'd25;
    localparam logic [4:0] AI_FOUR_BYTE = 5'd26;

    // Simple values
    localparam logic [7:0] BOOL_TRUE  = 8'hF5;
    localparam logic [7:0] BOOL_FALSE = 8'hF4;

    localparam logic [15:0] CAP_RESET = 16'd1024;
    localparam int          HEAD_MAX  = 5;

    // One burst of bytes handed from the front to the back
    typedef struct packed {
        logic [HEAD_MAX-1:0][7:0] bytes;     // bytes[0] goes out first
        logic [2:0]               count_m1;  // number of bytes minus one
        logic [15:0]              start;     // buffer offset of bytes[0]
    } job_t;

    // Queue status seen by the back and by the input gate of the top level
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// ===== design/cihe_job_fifo.sv =====
// Short job queue between the front classifier and the back serialiser.
module cihe_job_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cihe_pkg::job_t         push_job,
    input  logic                   pop,
    output cihe_pkg::job_t         head_job,
    output cihe_pkg::fifo_status_t status
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    cihe_pkg::job_t        slot_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign status.full  = (count_reg == CNT_BITS'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = slot_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage, payload only
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Occupancy never runs past the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("job queue overfilled");

    // Count rises by one after a push without a pop
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("job queue count lost a push");

endmodule

// ===== design/cihe_front.sv =====
// Front part: takes items, keeps fill and payload state, builds byte jobs.
module cihe_front #(
    parameter int POSITION_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [15:0]            cfg_data,
    input  logic                   item_valid,
    input  logic [3:0]             kind,
    input  logic [31:0]            value,
    input  logic [7:0]             data_byte,
    output logic                   job_push,
    output cihe_pkg::job_t         job
);

    localparam int          FILL_BITS = (POSITION_BITS < 16) ? POSITION_BITS : 16;
    localparam logic [16:0] POS_LIMIT = (POSITION_BITS >= 16) ? 17'h0FFFF
                                        : ((17'd1 << POSITION_BITS) - 17'd1);
    localparam int HEAD_BYTES = cihe_pkg::HEAD_MAX;

    typedef struct packed {
        logic [HEAD_BYTES-1:0][7:0] bytes;
        logic [2:0]                 count_m1;
    } head_t;

    logic [15:0]          cap_reg;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    logic [31:0]          remain_reg, remain_next;
    logic                 keep_reg, keep_next;

    logic [15:0]          eff_cap;
    logic [15:0]          fill16;
    logic [2:0]           major;
    logic [31:0]          arg;
    head_t                head;
    logic [16:0]          fill_after;
    logic                 head_fits;
    logic                 byte_fits;
    logic                 payload_fits;

    // Head encoding: initial byte then big-endian argument
    function automatic head_t encode_head(input logic [2:0] mt, input logic [31:0] a);
        head_t h;
        h.bytes = '0;
        if (a < 32'd24)
        begin
            h.bytes[0] = {mt, a[4:0]};
            h.count_m1 = 3'd0;
        end
        else if (a <= 32'hFF)
        begin
            h.bytes[0] = {mt, cihe_pkg::AI_ONE_BYTE};
            h.bytes[1] = a[7:0];
            h.count_m1 = 3'd1;
        end
        else if (a <= 32'hFFFF)
        begin
            h.bytes[0] = {mt, cihe_pkg::AI_TWO_BYTE};
            h.bytes[1] = a[15:8];
            h.bytes[2] = a[7:0];
            h.count_m1 = 3'd2;
        end
        else
        begin
            h.bytes[0] = {mt, cihe_pkg::AI_FOUR_BYTE};
            h.bytes[1] = a[31:24];
            h.bytes[2] = a[23:16];
            h.bytes[3] = a[15:8];
            h.bytes[4] = a[7:0];
            h.count_m1 = 3'd4;
        end
        return h;
    endfunction

    assign eff_cap = (cap_reg < POS_LIMIT[15:0]) ? cap_reg : POS_LIMIT[15:0];
    assign fill16  = 16'(fill_reg);

    // Major type and argument select
    always_comb
    begin
        arg = value;
        case (cihe_pkg::kind_t'(kind))
            cihe_pkg::KIND_SIGNED:
            begin
                major = value[31] ? cihe_pkg::MT_NEGATIVE : cihe_pkg::MT_UNSIGNED;
                arg   = value[31] ? ~value : value;
            end
            cihe_pkg::KIND_BYTES: major = cihe_pkg::MT_BYTES;
            cihe_pkg::KIND_TEXT:  major = cihe_pkg::MT_TEXT;
            cihe_pkg::KIND_ARRAY: major = cihe_pkg::MT_ARRAY;
            cihe_pkg::KIND_MAP:   major = cihe_pkg::MT_MAP;
            default:              major = cihe_pkg::MT_UNSIGNED;
        endcase
    end

    assign head         = encode_head(major, arg);
    assign fill_after   = {1'b0, fill16} + 17'(head.count_m1) + 17'd1;
    assign head_fits    = (fill_after <= {1'b0, eff_cap});
    assign byte_fits    = (fill16 < eff_cap);
    assign payload_fits = (33'(fill_after) + 33'(value)) <= 33'(eff_cap);

    // Item classification and state update
    always_comb
    begin
        fill_next    = fill_reg;
        remain_next  = remain_reg;
        keep_next    = keep_reg;
        job_push     = 1'b0;
        job.bytes    = head.bytes;
        job.count_m1 = head.count_m1;
        job.start    = fill16;
        if (item_valid)
        begin
            unique case (cihe_pkg::kind_t'(kind))
                cihe_pkg::KIND_RESTART:
                begin
                    fill_next   = '0;
                    remain_next = '0;
                    keep_next   = 1'b0;
                end
                cihe_pkg::KIND_UNSIGNED, cihe_pkg::KIND_SIGNED,
                cihe_pkg::KIND_ARRAY, cihe_pkg::KIND_MAP:
                begin
                    remain_next = '0;
                    keep_next   = 1'b0;
                    if (head_fits)
                    begin
                        job_push  = 1'b1;
                        fill_next = fill_after[FILL_BITS-1:0];
                    end
                end
                cihe_pkg::KIND_BYTES, cihe_pkg::KIND_TEXT:
                begin
                    remain_next = value;
                    keep_next   = head_fits && payload_fits;
                    if (head_fits)
                    begin
                        job_push  = 1'b1;
                        fill_next = fill_after[FILL_BITS-1:0];
                    end
                end
                cihe_pkg::KIND_BOOL:
                begin
                    remain_next  = '0;
                    keep_next    = 1'b0;
                    job.bytes    = '0;
                    job.bytes[0] = (value != '0) ? cihe_pkg::BOOL_TRUE
                                                 : cihe_pkg::BOOL_FALSE;
                    job.count_m1 = 3'd0;
                    if (byte_fits)
                    begin
                        job_push  = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                cihe_pkg::KIND_PAYLOAD:
                begin
                    job.bytes    = '0;
                    job.bytes[0] = data_byte;
                    job.count_m1 = 3'd0;
                    if (remain_reg != '0)
                    begin
                        remain_next = remain_reg - 1'b1;
                        if (keep_reg && byte_fits)
                        begin
                            job_push  = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    // unknown kinds leave everything as it is
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= cihe_pkg::CAP_RESET;
            fill_reg   <= '0;
            remain_reg <= '0;
            keep_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            fill_reg   <= fill_next;
            remain_reg <= remain_next;
            keep_reg   <= keep_next;
        end
    end

endmodule

// ===== design/cihe_back.sv =====
// Back part: serialises queued jobs into single result bytes.
module cihe_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cihe_pkg::fifo_status_t q_status,
    input  cihe_pkg::job_t         q_head,
    output logic                   q_pop,
    input  logic                   pop,
    output logic                   empty,
    output logic [7:0]             out_byte,
    output logic [15:0]            out_position,
    output logic                   last_of_run
);

    cihe_pkg::job_t job_reg, job_next;
    logic [2:0]     idx_reg, idx_next;
    logic           busy_reg, busy_next;
    logic           advance;
    logic           load;

    assign empty        = !busy_reg;
    assign last_of_run  = (idx_reg == job_reg.count_m1);
    assign out_byte     = job_reg.bytes[idx_reg];
    assign out_position = job_reg.start + 16'(idx_reg);

    assign advance = busy_reg && pop;
    assign load    = !busy_reg || (advance && last_of_run);
    assign q_pop   = load && !q_status.empty;

    // Byte index and job reload
    always_comb
    begin
        job_next  = job_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load)
        begin
            busy_next = !q_status.empty;
            job_next  = q_head;
            idx_next  = 3'd0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    // Index stays inside the current burst
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= job_reg.count_m1))
        else $error("byte index past end of burst");

    // Within a burst positions step by one
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !last_of_run) |=> (out_position == $past(out_position) + 16'd1))
        else $error("burst positions not consecutive");

endmodule

// ===== design/cbor_item_head_encoder_unit.sv =====
// Top level of the CBOR item head encoder: front, job queue and back.
//
//  channel   | signals                              | request moves
//  ----------+--------------------------------------+----------------------------
//  input     | push, full, kind, value, data_byte   | one item, push && !full
//  result    | pop, empty, out_byte, out_position,  | one byte, pop && !empty
//            | last_of_run                          |
//  config    | cfg_valid, cfg_ready, cfg_data       | buffer capacity write
//
// The front takes one item per cycle while the job queue has room; each item
// is classified and its head built in that same cycle.
// The back sends one byte per cycle while pop is held, so a head of n bytes
// holds the back until all n are sent; the JOB_DEPTH-entry queue absorbs that while the front runs on.
// Reset clears fill length, payload state and the queue; capacity returns to 1024.
// full rises only when the queue is full; a stalled result holds its ports.
module cbor_item_head_encoder_unit #(
    parameter int POSITION_BITS = 16,
    parameter int JOB_DEPTH     = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  kind,
    input  logic [31:0] value,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic [15:0] out_position,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    cihe_pkg::job_t         front_job;
    cihe_pkg::job_t         head_job;
    cihe_pkg::fifo_status_t q_status;
    logic                   job_push;
    logic                   q_pop;
    logic                   item_valid;

    assign cfg_ready  = 1'b1;
    assign full       = q_status.full;
    assign item_valid = push && !q_status.full;

    // Classifier and state keeper
    cihe_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .kind       (kind),
        .value      (value),
        .data_byte  (data_byte),
        .job_push   (job_push),
        .job        (front_job)
    );

    // Decoupling queue
    cihe_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (front_job),
        .pop      (q_pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Byte serialiser
    cihe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_head       (head_job),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .out_position (out_position),
        .last_of_run  (last_of_run)
    );

endmodule
